// ===== design/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// plain condition checked on every clock, including reset
`define ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ===== design/chs_pkg.sv =====
package chs_pkg;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] distinct_count;
    logic [9:0] bucket;
  } out_item_t;

  localparam logic [1:0] ST_DUP      = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  localparam int HASH_SHIFT = 6;

endpackage

// ===== design/chs_ram.sv =====
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/chained_hash_set_insert.sv =====
// Sequence: each byte holds busy while compare-subtract reduces hash*64 + byte below
// BUCKET_COUNT; a final byte then passes the head fetch, a compare of each position in
// each walked node, a chain-end check, a copy of a new key, a link and a report, with
// done high in the cycle after the report; a too-long key goes straight to the report.
// Throughput: one byte per transfer, the next taken once busy drops; results never stall.
// Reset: a clearing pass over all BUCKET_COUNT bucket heads keeps busy high.
`include "assert_macros.svh"
module chained_hash_set_insert #(
  parameter int BUCKET_COUNT  = 1021,
  parameter int NODE_COUNT    = 1023,
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  chs_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               done,
  output chs_pkg::out_item_t out_item
);
  import chs_pkg::*;

  localparam int BW = $clog2(BUCKET_COUNT) < 1 ? 1 : $clog2(BUCKET_COUNT);
  localparam int NW = $clog2(NODE_COUNT + 1);
  localparam int IW = $clog2(NODE_COUNT) < 1 ? 1 : $clog2(NODE_COUNT);
  localparam int KW = $clog2(MAX_KEY_BYTES) < 1 ? 1 : $clog2(MAX_KEY_BYTES);
  localparam int LW = $clog2(MAX_KEY_BYTES + 1);
  localparam int SW = IW + KW;
  localparam int SD = NODE_COUNT * (2 ** KW);
  localparam int HW = BW + HASH_SHIFT + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_NODE, S_NCHK, S_CMP, S_CMPCHK,
    S_COPY, S_LINK, S_DONE
  } state_t;

  state_t state;

  logic [BW-1:0] hash;
  logic [BW-1:0] res_bucket;
  logic [HW-1:0] acc;
  logic [LW-1:0] cur_len;
  logic          ovf;
  logic          last;
  logic [NW-1:0] used;
  logic [NW-1:0] ptr;
  logic [NW-1:0] steps;
  logic [LW-1:0] pos;
  logic [1:0]    st;
  logic [BW-1:0] clr;
  logic          hash_step_done;
  logic [NW-1:0] hd_keep;

  // memory ports
  logic          hd_we;
  logic [BW-1:0] hd_wa, hd_ra;
  logic [NW-1:0] hd_wd, hd_rd;
  logic          nx_we;
  logic [IW-1:0] nx_wa, nx_ra;
  logic [NW-1:0] nx_wd, nx_rd;
  logic          ln_we;
  logic [IW-1:0] ln_wa, ln_ra;
  logic [LW-1:0] ln_wd, ln_rd;
  logic          kb_we;
  logic [SW-1:0] kb_wa, kb_ra;
  logic [7:0]    kb_wd, kb_rd;
  logic          ck_we;
  logic [KW-1:0] ck_wa, ck_ra;
  logic [7:0]    ck_wd, ck_rd;

  chs_ram #(.WIDTH(NW), .DEPTH(BUCKET_COUNT)) u_heads (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  chs_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  chs_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_len (
    .clk, .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
  chs_ram #(.WIDTH(8), .DEPTH(SD)) u_keys (
    .clk, .we(kb_we), .waddr(kb_wa), .wdata(kb_wd), .raddr(kb_ra), .rdata(kb_rd));
  chs_ram #(.WIDTH(8), .DEPTH(2 ** KW)) u_cur (
    .clk, .we(ck_we), .waddr(ck_wa), .wdata(ck_wd), .raddr(ck_ra), .rdata(ck_rd));

  // compare-subtract unit for hashing: one BUCKET_COUNT off acc per cycle
  logic [HW-1:0] acc_red;
  assign acc_red = (acc >= HW'(BUCKET_COUNT)) ? acc - HW'(BUCKET_COUNT) : acc;
  assign hash_step_done = (acc < HW'(BUCKET_COUNT));

  logic [IW-1:0] node_idx;
  assign node_idx = IW'(ptr - NW'(1));
  logic [IW-1:0] new_idx;
  assign new_idx  = IW'(used);

  // memory control
  always_comb begin
    hd_we = 1'b0; hd_wa = hash; hd_wd = used + NW'(1); hd_ra = hash;
    nx_we = 1'b0; nx_wa = new_idx; nx_wd = ptr; nx_ra = node_idx;
    ln_we = 1'b0; ln_wa = new_idx; ln_wd = cur_len; ln_ra = node_idx;
    kb_we = 1'b0; kb_wa = {new_idx, pos[KW-1:0]}; kb_wd = ck_rd;
    kb_ra = {node_idx, pos[KW-1:0]};
    ck_we = 1'b0; ck_wa = cur_len[KW-1:0]; ck_wd = in_item.key_byte;
    ck_ra = pos[KW-1:0];
    unique case (state)
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr; hd_wd = '0;
      end
      S_IDLE: begin
        ck_we = start && (cur_len < LW'(MAX_KEY_BYTES));
      end
      S_COPY: begin
        kb_we = (pos != '0);
        kb_wa = {new_idx, KW'(pos - LW'(1))};
      end
      S_LINK: begin
        hd_we = 1'b1; nx_we = 1'b1; ln_we = 1'b1;
        nx_wd = hd_keep;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      hash    <= '0;
      cur_len <= '0;
      ovf     <= 1'b0;
      used    <= '0;
      done    <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_CLEAR: begin
          clr <= clr + BW'(1);
          if (clr == BW'(BUCKET_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            acc  <= HW'({hash, HASH_SHIFT'(0)}) + HW'(in_item.key_byte);
            last <= in_item.last_byte;
            if (cur_len < LW'(MAX_KEY_BYTES)) cur_len <= cur_len + LW'(1);
            else ovf <= 1'b1;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          acc <= acc_red;
          if (hash_step_done) begin
            hash <= BW'(acc);
            if (!last) state <= S_IDLE;
            else if (ovf) begin
              st <= ST_TOO_LONG; state <= S_DONE;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          // head read for the new hash is issued here; its data arrives in S_NODE
          steps <= '0;
          state <= S_NODE;
          ptr   <= '0;
          pos   <= '0;
        end
        S_NODE: begin
          if (steps == '0 && ptr == '0) ptr <= hd_rd;
          pos   <= '0;
          state <= S_NCHK;
        end
        S_NCHK: begin
          // chain end test
          if (ptr == '0 || ptr > used || steps >= NW'(NODE_COUNT)) begin
            if (used >= NW'(NODE_COUNT)) begin
              st <= ST_FULL; state <= S_DONE;
            end else begin
              pos <= '0; state <= S_COPY;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // length and byte reads for pos are in flight
          state <= S_CMPCHK;
        end
        S_CMPCHK: begin
          if (ln_rd != cur_len || (pos != cur_len && kb_rd != ck_rd)) begin
            ptr   <= nx_rd;
            steps <= steps + NW'(1);
            pos   <= '0;
            if (nx_rd == '0 || nx_rd > used || steps + NW'(1) >= NW'(NODE_COUNT))
              state <= S_NCHK;
            else
              state <= S_CMP;
          end else if (pos == cur_len) begin
            st <= ST_DUP; state <= S_DONE;
          end else begin
            pos   <= pos + LW'(1);
            state <= S_CMP;
          end
        end
        S_COPY: begin
          // byte pos-1 read last cycle is written now
          if (pos == cur_len) state <= S_LINK;
          else pos <= pos + LW'(1);
        end
        S_LINK: begin
          ptr   <= '0;
          used  <= used + NW'(1);
          st    <= ST_NEW;
          state <= S_DONE;
        end
        S_DONE: begin
          res_bucket <= hash;
          hash    <= '0;
          cur_len <= '0;
          ovf     <= 1'b0;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // old chain head for the link step
  always_ff @(posedge clk) begin
    if (state == S_NODE) begin
      hd_keep <= hd_rd;
    end
  end

  assign busy = (state != S_IDLE);
  assign out_item.status         = st;
  assign out_item.distinct_count = 10'(used);
  assign out_item.bucket         = 10'(res_bucket);

  `ASSERT_IMPL(a_done_idle, clk, rst, done |-> state == S_IDLE, "done outside idle")
  `ASSERT_IMPL(a_used_max, clk, rst, used <= NW'(NODE_COUNT), "node count overrun")
  `ASSERT_IMPL(a_len_max, clk, rst, cur_len <= LW'(MAX_KEY_BYTES), "key length overrun")
endmodule
